// ===== sv/clcd_pkg.sv =====
// Shared types, codes and constants for the character-LCD 4-bit command encoder.
// Used by every module of the block; depends on nothing.
package clcd_pkg;

  // request queue between front and back
  localparam int QPTR_W = 2;
  localparam int QDEPTH = 1 << QPTR_W;
  localparam int QCNT_W = QPTR_W + 1;

  // request opcodes
  typedef enum logic [3:0] {
    OP_INIT      = 4'd0,
    OP_CLEAR     = 4'd1,
    OP_HOME      = 4'd2,
    OP_DISPLAY   = 4'd3,
    OP_CURSOR    = 4'd4,
    OP_BLINK     = 4'd5,
    OP_BACKLIGHT = 4'd6,
    OP_SET_CURSOR = 4'd7,
    OP_WRITE_CHAR = 4'd8,
    OP_GLYPH     = 4'd9
  } op_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_ROWS       = 2'd0,
    CFG_BL_PRESENT = 2'd1,
    CFG_SETTLE     = 2'd2
  } cfg_idx_t;

  // kind of job handed to the back end
  typedef enum logic [1:0] {
    KIND_INIT,
    KIND_BYTE,
    KIND_GLYPH,
    KIND_BLIGHT
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic        rs;          // register select of the first byte
    logic [7:0]  cmd_byte;    // first (or only) byte
    logic        long_wait;   // clear/home wait after the low nibble
    logic [63:0] rows;        // glyph row bytes
    logic        backlight;   // backlight level after the request
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } push_t;

  typedef struct packed {
    logic [2:0] row_count;
    logic       bl_present;
  } front_cfg_t;

  typedef struct packed {
    logic [3:0]  nibble;
    logic [15:0] wait_before;
    logic [12:0] wait_after;
  } init_ev_t;

  // waits in microseconds
  localparam logic [15:0] WAIT_POWER_US      = 16'd50000;
  localparam logic [12:0] WAIT_INIT_LONG_US  = 13'd5000;
  localparam logic [12:0] WAIT_INIT_SHORT_US = 13'd150;
  localparam logic [12:0] WAIT_CLEAR_US      = 13'd2000;

  // controller command bytes
  localparam logic [7:0] CMD_CLEAR     = 8'h01;
  localparam logic [7:0] CMD_HOME      = 8'h02;
  localparam logic [7:0] CMD_ENTRY     = 8'h06;
  localparam logic [7:0] CMD_DISPLAY   = 8'h08;
  localparam logic [7:0] CMD_FUNCTION  = 8'h28;
  localparam logic [7:0] CMD_SET_CGRAM = 8'h40;
  localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
  localparam logic [3:0] NIB_WAKE      = 4'h3;
  localparam logic [3:0] NIB_FOUR_BIT  = 4'h2;

  // display bits after init: display on, cursor off, blink off
  localparam logic [2:0] DISP_INIT  = 3'b100;
  localparam logic [2:0] DISP_MASK  = 3'b100;
  localparam logic [2:0] CURS_MASK  = 3'b010;
  localparam logic [2:0] BLINK_MASK = 3'b001;

  localparam logic [4:0] INIT_LAST  = 5'd11;
  localparam logic [4:0] GLYPH_LAST = 5'd17;

  // DDRAM offset of each row
  function automatic logic [7:0] row_base(input logic [1:0] row);
    logic [7:0] base;
    case (row)
      2'd0:    base = 8'h00;
      2'd1:    base = 8'h40;
      2'd2:    base = 8'h14;
      default: base = 8'h54;
    endcase
    return base;
  endfunction

  // power-up sequence, one entry per nibble event
  function automatic init_ev_t init_event(input logic [4:0] step);
    init_ev_t   ev;
    logic [7:0] disp;
    disp = CMD_DISPLAY | {5'd0, DISP_INIT};
    ev   = '{nibble: 4'h0, wait_before: 16'd0, wait_after: 13'd0};
    case (step)
      5'd0:  ev = '{nibble: NIB_WAKE, wait_before: WAIT_POWER_US,
                    wait_after: WAIT_INIT_LONG_US};
      5'd1:  ev = '{nibble: NIB_WAKE, wait_before: 16'd0, wait_after: WAIT_INIT_LONG_US};
      5'd2:  ev = '{nibble: NIB_WAKE, wait_before: 16'd0, wait_after: WAIT_INIT_SHORT_US};
      5'd3:  ev.nibble = NIB_FOUR_BIT;
      5'd4:  ev.nibble = CMD_FUNCTION[7:4];
      5'd5:  ev.nibble = CMD_FUNCTION[3:0];
      5'd6:  ev.nibble = disp[7:4];
      5'd7:  ev.nibble = disp[3:0];
      5'd8:  ev.nibble = CMD_CLEAR[7:4];
      5'd9:  ev = '{nibble: CMD_CLEAR[3:0], wait_before: 16'd0, wait_after: WAIT_CLEAR_US};
      5'd10: ev.nibble = CMD_ENTRY[7:4];
      5'd11: ev.nibble = CMD_ENTRY[3:0];
      default: ev.nibble = 4'h0;
    endcase
    return ev;
  endfunction

endpackage

// ===== sv/clcd_front.sv =====
// Front end: accepts requests, keeps display and backlight state, builds jobs.
// Depends on clcd_pkg.
module clcd_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [3:0]            opcode,
  input  logic                  switch_on,
  input  logic [1:0]            cursor_row,
  input  logic [6:0]            cursor_col,
  input  logic [7:0]            char_code,
  input  logic [7:0]            glyph_slot,
  input  logic [63:0]           glyph_rows,
  input  clcd_pkg::front_cfg_t  cfg,
  input  logic                  full,
  output clcd_pkg::push_t       push
);

  logic [2:0] display_bits, display_bits_next;
  logic       backlight_on, backlight_on_next;
  logic       accept;
  logic       known;
  logic [2:0] rows_eff;
  logic [1:0] row_c;
  logic [7:0] ddram;
  clcd_pkg::job_t job;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  // row clamp and DDRAM address for set cursor
  always_comb begin
    rows_eff = (cfg.row_count == 3'd0) ? 3'd1 : cfg.row_count;
    row_c    = cursor_row;
    if ({1'b0, cursor_row} >= rows_eff) begin
      row_c = 2'(rows_eff - 3'd1);
    end
    ddram = clcd_pkg::CMD_SET_DDRAM | ({1'b0, cursor_col} + clcd_pkg::row_base(row_c));
  end

  // classify the request
  always_comb begin
    display_bits_next = display_bits;
    backlight_on_next = backlight_on;
    known             = 1'b1;
    job.kind          = clcd_pkg::KIND_BYTE;
    job.rs            = 1'b0;
    job.cmd_byte      = 8'h00;
    job.long_wait     = 1'b0;
    job.rows          = glyph_rows;
    unique case (clcd_pkg::op_t'(opcode))
      clcd_pkg::OP_INIT: begin
        if (cfg.bl_present) backlight_on_next = 1'b1;
        display_bits_next = clcd_pkg::DISP_INIT;
        job.kind          = clcd_pkg::KIND_INIT;
      end
      clcd_pkg::OP_CLEAR: begin
        job.cmd_byte  = clcd_pkg::CMD_CLEAR;
        job.long_wait = 1'b1;
      end
      clcd_pkg::OP_HOME: begin
        job.cmd_byte  = clcd_pkg::CMD_HOME;
        job.long_wait = 1'b1;
      end
      clcd_pkg::OP_DISPLAY: begin
        display_bits_next = switch_on ? (display_bits | clcd_pkg::DISP_MASK)
                                      : (display_bits & ~clcd_pkg::DISP_MASK);
        job.cmd_byte = clcd_pkg::CMD_DISPLAY | {5'd0, display_bits_next};
      end
      clcd_pkg::OP_CURSOR: begin
        display_bits_next = switch_on ? (display_bits | clcd_pkg::CURS_MASK)
                                      : (display_bits & ~clcd_pkg::CURS_MASK);
        job.cmd_byte = clcd_pkg::CMD_DISPLAY | {5'd0, display_bits_next};
      end
      clcd_pkg::OP_BLINK: begin
        display_bits_next = switch_on ? (display_bits | clcd_pkg::BLINK_MASK)
                                      : (display_bits & ~clcd_pkg::BLINK_MASK);
        job.cmd_byte = clcd_pkg::CMD_DISPLAY | {5'd0, display_bits_next};
      end
      clcd_pkg::OP_BACKLIGHT: begin
        if (cfg.bl_present) backlight_on_next = switch_on;
        job.kind = clcd_pkg::KIND_BLIGHT;
      end
      clcd_pkg::OP_SET_CURSOR: begin
        job.cmd_byte = ddram;
      end
      clcd_pkg::OP_WRITE_CHAR: begin
        job.rs       = 1'b1;
        job.cmd_byte = char_code;
      end
      clcd_pkg::OP_GLYPH: begin
        job.kind     = clcd_pkg::KIND_GLYPH;
        job.cmd_byte = clcd_pkg::CMD_SET_CGRAM | {2'b00, glyph_slot[2:0], 3'b000};
      end
      default: begin
        // unknown opcode: dropped without effect
        known = 1'b0;
      end
    endcase
    job.backlight = backlight_on_next;
  end

  assign push.valid = accept && known;
  assign push.job   = job;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      display_bits <= 3'd0;
      backlight_on <= 1'b0;
    end else if (accept) begin
      display_bits <= display_bits_next;
      backlight_on <= backlight_on_next;
    end
  end

endmodule

// ===== sv/clcd_queue.sv =====
// Short job queue between the front and back ends.
// Depends on clcd_pkg.
module clcd_queue (
  input  logic            clk,
  input  logic            rst,
  input  clcd_pkg::push_t push,
  output logic            full,
  output logic            head_valid,
  output clcd_pkg::job_t  head,
  input  logic            pop
);

  clcd_pkg::job_t                     mem [clcd_pkg::QDEPTH];
  logic [clcd_pkg::QPTR_W-1:0]        wr_ptr, rd_ptr;
  logic [clcd_pkg::QCNT_W-1:0]        count;

  assign full       = (count == clcd_pkg::QCNT_W'(clcd_pkg::QDEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push.valid) mem[wr_ptr] <= push.job;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) wr_ptr <= wr_ptr + 1'b1;
      if (pop)        rd_ptr <= rd_ptr + 1'b1;
      if (push.valid && !pop)      count <= count + 1'b1;
      else if (pop && !push.valid) count <= count - 1'b1;
    end
  end

endmodule

// ===== sv/clcd_back.sv =====
// Back end: expands the head job into nibble events, one per cycle, into the
// output register while it is empty or taken. Depends on clcd_pkg.
module clcd_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            job_valid,
  input  clcd_pkg::job_t  job,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            out_rs,
  output logic [3:0]      out_nibble,
  output logic            out_strobe,
  output logic [15:0]     out_wait_before,
  output logic [12:0]     out_wait_after,
  output logic            out_backlight,
  output logic            out_last
);

  logic [4:0]  step;
  logic        load;
  logic        ev_rs, ev_strobe, ev_last;
  logic [3:0]  ev_nibble;
  logic [15:0] ev_wb;
  logic [12:0] ev_wa;
  logic [7:0]  cur_byte;
  logic [3:0]  row_idx;
  clcd_pkg::init_ev_t iev;

  // event for the current step of the head job
  always_comb begin
    iev       = clcd_pkg::init_event(step);
    row_idx   = step[4:1] - 4'd1;
    cur_byte  = job.cmd_byte;
    ev_rs     = job.rs;
    ev_strobe = 1'b1;
    ev_nibble = 4'h0;
    ev_wb     = 16'd0;
    ev_wa     = 13'd0;
    ev_last   = 1'b0;
    unique case (job.kind)
      clcd_pkg::KIND_INIT: begin
        ev_rs     = 1'b0;
        ev_nibble = iev.nibble;
        ev_wb     = iev.wait_before;
        ev_wa     = iev.wait_after;
        ev_last   = (step == clcd_pkg::INIT_LAST);
      end
      clcd_pkg::KIND_BYTE: begin
        ev_nibble = step[0] ? cur_byte[3:0] : cur_byte[7:4];
        ev_wa     = (step[0] && job.long_wait) ? clcd_pkg::WAIT_CLEAR_US : 13'd0;
        ev_last   = step[0];
      end
      clcd_pkg::KIND_GLYPH: begin
        if (step >= 5'd2) begin
          cur_byte = job.rows[{row_idx[2:0], 3'b000} +: 8];
          ev_rs    = 1'b1;
        end
        ev_nibble = step[0] ? cur_byte[3:0] : cur_byte[7:4];
        ev_last   = (step == clcd_pkg::GLYPH_LAST);
      end
      clcd_pkg::KIND_BLIGHT: begin
        ev_rs     = 1'b0;
        ev_strobe = 1'b0;
        ev_last   = 1'b1;
      end
      default: begin
        ev_last = 1'b1;
      end
    endcase
  end

  assign load = job_valid && (!out_valid || out_ready);
  assign pop  = load && ev_last;

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= 5'd0;
    end else if (load) begin
      step <= ev_last ? 5'd0 : step + 5'd1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_rs          <= ev_rs;
      out_nibble      <= ev_nibble;
      out_strobe      <= ev_strobe;
      out_wait_before <= ev_wb;
      out_wait_after  <= ev_wa;
      out_backlight   <= job.backlight;
      out_last        <= ev_last;
    end
  end

endmodule

// ===== sv/char_lcd_4bit_command_encoder.sv =====
// Top level of the character-LCD 4-bit command encoder: configuration
// registers, front end, job queue and back end. Depends on clcd_pkg.
//
//   channel   direction  handshake            payload
//   s_*       in         s_tvalid / s_tready  s_tuser opcode, s_tdata request fields
//   m_*       out        m_tvalid / m_tready  m_tuser RS, m_tdata event, m_tlast
//   cfg_*     in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// A request is taken whenever the four-entry job queue has room.
// The back end sends one nibble event per cycle while m_tready does not stall it:
// 1 to 18 events per request (2 for a byte, 12 for init, 18 for a glyph).
// Synchronous reset clears state, queue and output register; no sweep needed.
// A stalled m_tready holds the output register; requests keep queueing
// until the queue fills. cfg_ready is always high.
module char_lcd_4bit_command_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [3:0]  s_tuser,   // [3:0] opcode
  input  logic [95:0] s_tdata,   // [0] switch_on, [2:1] cursor_row, [9:3] cursor_col,
                                 // [17:10] char_code, [25:18] glyph_slot,
                                 // [89:26] glyph_rows, [95:90] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic        m_tuser,   // [0] register_select
  output logic [39:0] m_tdata,   // [3:0] nibble, [4] strobe_res, [20:5] wait_before_us,
                                 // [33:21] wait_after_us, [34] backlight, [39:35] zero
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data
);

  logic [2:0]  row_count;
  logic        backlight_present;
  logic [9:0]  settle_wait_us;
  logic        cfg_wr;

  clcd_pkg::front_cfg_t fcfg;
  clcd_pkg::push_t      push;
  clcd_pkg::job_t       head;
  logic                 full, head_valid, pop;
  logic [3:0]           nibble;
  logic                 strobe;
  logic [15:0]          wait_before;
  logic [12:0]          wait_after;
  logic                 backlight;

  // configuration registers
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count         <= 3'd2;
      backlight_present <= 1'b1;
      settle_wait_us    <= 10'd100;
    end else if (cfg_wr) begin
      if (cfg_index == clcd_pkg::CFG_ROWS)       row_count         <= cfg_data[2:0];
      if (cfg_index == clcd_pkg::CFG_BL_PRESENT) backlight_present <= cfg_data[0];
      if (cfg_index == clcd_pkg::CFG_SETTLE)     settle_wait_us    <= cfg_data;
    end
  end

  assign fcfg.row_count  = row_count;
  assign fcfg.bl_present = backlight_present;

  clcd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .opcode     (s_tuser),
    .switch_on  (s_tdata[0]),
    .cursor_row (s_tdata[2:1]),
    .cursor_col (s_tdata[9:3]),
    .char_code  (s_tdata[17:10]),
    .glyph_slot (s_tdata[25:18]),
    .glyph_rows (s_tdata[89:26]),
    .cfg        (fcfg),
    .full       (full),
    .push       (push)
  );

  clcd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  clcd_back u_back (
    .clk             (clk),
    .rst             (rst),
    .job_valid       (head_valid),
    .job             (head),
    .pop             (pop),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .out_rs          (m_tuser),
    .out_nibble      (nibble),
    .out_strobe      (strobe),
    .out_wait_before (wait_before),
    .out_wait_after  (wait_after),
    .out_backlight   (backlight),
    .out_last        (m_tlast)
  );

  assign m_tdata = {5'd0, backlight, wait_after, wait_before, strobe, nibble};

  // checks
  a_out_cleared: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_blight_quiet: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !strobe) |-> (nibble == 4'h0 && !m_tuser && m_tlast))
    else $error("backlight-only event carries data");

  a_power_wait: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && wait_before != 16'd0) |-> (nibble == clcd_pkg::NIB_WAKE && !m_tuser))
    else $error("power-up wait on wrong event");

  a_settle_hold: assert property (@(posedge clk) disable iff (rst)
    !(cfg_wr && cfg_index == clcd_pkg::CFG_SETTLE) |=> $stable(settle_wait_us))
    else $error("settle wait changed without a write");

endmodule

// ===== test/char_lcd_4bit_command_encoder_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for char_lcd_4bit_command_encoder: a directed request table, then
// random requests over several register settings, checked against a local encoder model
// or hand-written rows. Depends on clcd_pkg and the encoder RTL.
module char_lcd_4bit_command_encoder_tb;
  import clcd_pkg::*;

  // opcodes the encoder has no use for
  localparam logic [3:0] OP_SPARE_LO  = 4'hA;
  localparam logic [3:0] OP_SPARE_HI  = 4'hF;
  localparam int         N_SCRIPT     = 23;
  localparam int         N_PHASES     = 6;
  localparam int         PHASE_WORDS  = 48;
  localparam int         DRAIN_CYCLES = 80;

  localparam logic [2:0] PHASE_ROWS [N_PHASES] = '{3'd0, 3'd4, 3'd1, 3'd7, 3'd3, 3'd2};
  localparam logic       PHASE_BL   [N_PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
  localparam logic [9:0] PHASE_SETTLE [N_PHASES] =
    '{10'd0, 10'd1023, 10'd512, 10'd0, 10'd100, 10'd1023};

  typedef struct {
    logic [3:0]  op;
    logic        on;
    logic [1:0]  row;
    logic [6:0]  col;
    logic [7:0]  chr;
    logic [7:0]  slot;
    logic [63:0] glyph;
  } lcd_req_t;

  // request plus an optional hand-written result (single event or none)
  typedef struct {
    lcd_req_t req;
    logic     known;
    logic     known_event;
    logic     known_bl;
  } script_row_t;

  typedef struct packed {
    logic        rs;
    logic [3:0]  nibble;
    logic        strobe;
    logic [15:0] wait_before;
    logic [12:0] wait_after;
    logic        backlight;
    logic        last;
  } lcd_event_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [3:0]  s_tuser   = 4'd0;
  logic [95:0] s_tdata   = '0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic        m_tuser;
  logic [39:0] m_tdata;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_ROWS;
  logic [9:0]  cfg_data  = '0;

  // expected bus events, oldest first
  lcd_event_t pending_events[$];

  // encoder model state and registers
  logic [2:0] model_disp     = 3'd0;
  logic       model_bl       = 1'b0;
  logic [2:0] cfg_rows       = 3'd2;
  logic       cfg_bl_present = 1'b1;
  logic [9:0] cfg_settle     = 10'd100;

  int error_count = 0;
  int tx_idle_pct = 9;
  int rx_idle_pct = 66;

  script_row_t script [N_SCRIPT];
  lcd_event_t  got_event;
  lcd_event_t  want_event;

  char_lcd_4bit_command_encoder i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tuser   (m_tuser),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  function automatic void add_event(input logic rs, input logic [3:0] nib, input logic strobe,
                                    input logic [15:0] wb, input logic [12:0] wa);
    pending_events.push_back('{rs: rs, nibble: nib, strobe: strobe, wait_before: wb,
                               wait_after: wa, backlight: model_bl, last: 1'b0});
  endfunction

  // byte goes out high nibble first; the long wait hangs off the low nibble
  function automatic void add_byte(input logic rs, input logic [7:0] b,
                                   input logic [12:0] wa_low);
    add_event(rs, b[7:4], 1'b1, 16'd0, 13'd0);
    add_event(rs, b[3:0], 1'b1, 16'd0, wa_low);
  endfunction

  // turn one request into its bus events and update the model state
  function automatic void encode_request(input lcd_req_t r);
    int         start;
    logic [2:0] mask;
    logic [2:0] rows;
    logic [1:0] row;
    logic [7:0] base;
    start = pending_events.size();
    case (r.op)
      OP_INIT: begin
        if (cfg_bl_present) model_bl = 1'b1;
        model_disp = 3'b100;
        add_event(1'b0, 4'h3, 1'b1, 16'd50000, 13'd5000);
        add_event(1'b0, 4'h3, 1'b1, 16'd0, 13'd5000);
        add_event(1'b0, 4'h3, 1'b1, 16'd0, 13'd150);
        add_event(1'b0, 4'h2, 1'b1, 16'd0, 13'd0);
        add_byte(1'b0, 8'h28, 13'd0);
        add_byte(1'b0, {5'b00001, model_disp}, 13'd0);
        add_byte(1'b0, 8'h01, 13'd2000);
        add_byte(1'b0, 8'h06, 13'd0);
      end
      OP_CLEAR: add_byte(1'b0, 8'h01, 13'd2000);
      OP_HOME:  add_byte(1'b0, 8'h02, 13'd2000);
      OP_DISPLAY, OP_CURSOR, OP_BLINK: begin
        mask = (r.op == OP_DISPLAY) ? 3'b100 : (r.op == OP_CURSOR) ? 3'b010 : 3'b001;
        model_disp = r.on ? (model_disp | mask) : (model_disp & ~mask);
        add_byte(1'b0, {5'b00001, model_disp}, 13'd0);
      end
      OP_BACKLIGHT: begin
        if (cfg_bl_present) model_bl = r.on;
        add_event(1'b0, 4'h0, 1'b0, 16'd0, 13'd0);
      end
      OP_SET_CURSOR: begin
        // zero rows counts as one; row clamps to the last row
        rows = (cfg_rows == 3'd0) ? 3'd1 : cfg_rows;
        row  = ({1'b0, r.row} >= rows) ? 2'(rows - 3'd1) : r.row;
        case (row)
          2'd0:    base = 8'h00;
          2'd1:    base = 8'h40;
          2'd2:    base = 8'h14;
          default: base = 8'h54;
        endcase
        add_byte(1'b0, 8'h80 | ({1'b0, r.col} + base), 13'd0);
      end
      OP_WRITE_CHAR: add_byte(1'b1, r.chr, 13'd0);
      OP_GLYPH: begin
        add_byte(1'b0, {2'b01, r.slot[2:0], 3'b000}, 13'd0);
        for (int i = 0; i < 8; i++) add_byte(1'b1, r.glyph[8*i +: 8], 13'd0);
      end
      default: ;
    endcase
    if (pending_events.size() > start) pending_events[pending_events.size() - 1].last = 1'b1;
  endfunction

  function automatic script_row_t random_word();
    script_row_t w;
    if ($urandom_range(99) < 5) w.req.op = 4'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
    else                        w.req.op = 4'($urandom_range(OP_GLYPH, OP_INIT));
    w.req.on    = 1'($urandom);
    w.req.row   = 2'($urandom);
    w.req.col   = 7'($urandom);
    w.req.chr   = 8'($urandom);
    w.req.slot  = 8'($urandom);
    w.req.glyph = {$urandom, $urandom};
    w.known       = 1'b0;
    w.known_event = 1'b0;
    w.known_bl    = 1'b0;
    return w;
  endfunction

  function automatic void check_field(input string what, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      error_count++;
    end
  endfunction

  // present one request word and log its expected events once taken
  task automatic send_word(input script_row_t w);
    int start;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= w.req.op;
    s_tdata  <= {6'd0, w.req.glyph, w.req.slot, w.req.chr, w.req.col, w.req.row, w.req.on};
    do @(posedge clk); while (!s_tready);
    start = pending_events.size();
    encode_request(w.req);
    // hand-written rows replace the model's events
    if (w.known) begin
      while (pending_events.size() > start) void'(pending_events.pop_back());
      if (w.known_event)
        pending_events.push_back('{rs: 1'b0, nibble: 4'h0, strobe: 1'b0, wait_before: 16'd0,
                                   wait_after: 13'd0, backlight: w.known_bl, last: 1'b1});
    end
  endtask

  // hold off the sender until every expected event is out
  task automatic drain(input int extra);
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_events.size() != 0);
    repeat (extra) @(posedge clk);
  endtask

  task automatic configure(input logic [2:0] rows, input logic bl_present,
                           input logic [9:0] settle);
    cfg_idx_t   idx [3];
    logic [9:0] val [3];
    idx = '{CFG_ROWS, CFG_BL_PRESENT, CFG_SETTLE};
    val = '{{7'd0, rows}, {9'd0, bl_present}, settle};
    drain(DRAIN_CYCLES);
    for (int k = 0; k < 3; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid      <= 1'b0;
    cfg_rows       = rows;
    cfg_bl_present = bl_present;
    cfg_settle     = settle;
  endtask

  // output monitor: compare each accepted word with the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_event = '{rs: m_tuser, nibble: m_tdata[3:0], strobe: m_tdata[4],
                    wait_before: m_tdata[20:5], wait_after: m_tdata[33:21],
                    backlight: m_tdata[34], last: m_tlast};
      if (pending_events.size() == 0) begin
        $display("%0t ns: unexpected word, expected none, got %p", $time, got_event);
        error_count++;
      end else begin
        want_event = pending_events.pop_front();
        check_field("register_select", want_event.rs, got_event.rs);
        check_field("nibble", want_event.nibble, got_event.nibble);
        check_field("strobe_res", want_event.strobe, got_event.strobe);
        check_field("wait_before_us", want_event.wait_before, got_event.wait_before);
        check_field("wait_after_us", want_event.wait_after, got_event.wait_after);
        check_field("backlight", want_event.backlight, got_event.backlight);
        check_field("last", want_event.last, got_event.last);
      end
    end
  end

  // stimulus
  initial begin
    script_row_t w;
    int          counted;
    logic [9:0]  settle;
    script = '{
      // backlight straight after reset, register says present
      '{'{OP_BACKLIGHT,  1'b1, 2'd0, 7'd0,   8'h00, 8'h00, 64'd0}, 1'b1, 1'b1, 1'b1},
      '{'{OP_BACKLIGHT,  1'b0, 2'd0, 7'd0,   8'h00, 8'h00, 64'd0}, 1'b1, 1'b1, 1'b0},
      // display bit before init
      '{'{OP_DISPLAY,    1'b1, 2'd0, 7'd0,   8'h00, 8'h00, 64'd0}, 1'b0, 1'b0, 1'b0},
      '{'{OP_INIT,       1'b0, 2'd0, 7'd0,   8'h00, 8'h00, 64'd0}, 1'b0, 1'b0, 1'b0},
      '{'{OP_CLEAR,      1'b0, 2'd0, 7'd0,   8'h00, 8'h00, 64'd0}, 1'b0, 1'b0, 1'b0},
      '{'{OP_HOME,       1'b1, 2'd3, 7'h7F,  8'hFF, 8'hFF, '1},    1'b0, 1'b0, 1'b0},
      '{'{OP_DISPLAY,    1'b0, 2'd0, 7'd0,   8'h00, 8'h00, 64'd0}, 1'b0, 1'b0, 1'b0},
      '{'{OP_CURSOR,     1'b1, 2'd0, 7'd0,   8'h00, 8'h00, 64'd0}, 1'b0, 1'b0, 1'b0},
      '{'{OP_BLINK,      1'b1, 2'd0, 7'd0,   8'h00, 8'h00, 64'd0}, 1'b0, 1'b0, 1'b0},
      '{'{OP_BLINK,      1'b0, 2'd0, 7'd0,   8'h00, 8'h00, 64'd0}, 1'b0, 1'b0, 1'b0},
      '{'{OP_SET_CURSOR, 1'b0, 2'd0, 7'd0,   8'h00, 8'h00, 64'd0}, 1'b0, 1'b0, 1'b0},
      // row above the row count clamps; column carries into the top address bit
      '{'{OP_SET_CURSOR, 1'b0, 2'd3, 7'h7F,  8'h00, 8'h00, 64'd0}, 1'b0, 1'b0, 1'b0},
      '{'{OP_SET_CURSOR, 1'b1, 2'd1, 7'h7F,  8'hFF, 8'hFF, '1},    1'b0, 1'b0, 1'b0},
      '{'{OP_WRITE_CHAR, 1'b1, 2'd3, 7'h7F,  8'h00, 8'hFF, '1},    1'b0, 1'b0, 1'b0},
      '{'{OP_WRITE_CHAR, 1'b0, 2'd0, 7'd0,   8'hFF, 8'h00, 64'd0}, 1'b0, 1'b0, 1'b0},
      '{'{OP_GLYPH,      1'b0, 2'd0, 7'd0,   8'h00, 8'h00, 64'd0}, 1'b0, 1'b0, 1'b0},
      '{'{OP_GLYPH,      1'b1, 2'd3, 7'h7F,  8'hFF, 8'hFF, '1},    1'b0, 1'b0, 1'b0},
      '{'{OP_GLYPH,      1'b0, 2'd1, 7'h2A,  8'h5A, 8'h05, 64'h0123456789ABCDEF},
        1'b0, 1'b0, 1'b0},
      // unused opcodes give nothing
      '{'{OP_SPARE_LO,   1'b1, 2'd3, 7'h7F,  8'hFF, 8'hFF, '1},    1'b1, 1'b0, 1'b0},
      '{'{OP_SPARE_HI,   1'b0, 2'd0, 7'd0,   8'h00, 8'h00, 64'd0}, 1'b1, 1'b0, 1'b0},
      '{'{OP_BACKLIGHT,  1'b1, 2'd0, 7'd0,   8'h00, 8'h00, 64'd0}, 1'b1, 1'b1, 1'b1},
      '{'{OP_CURSOR,     1'b0, 2'd0, 7'd0,   8'h00, 8'h00, 64'd0}, 1'b0, 1'b0, 1'b0},
      '{'{OP_DISPLAY,    1'b1, 2'd0, 7'd0,   8'h00, 8'h00, 64'd0}, 1'b0, 1'b0, 1'b0}
    };
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) send_word(script[i]);

    // random phases: sender light / receiver heavy, then reversed, then flat out
    for (int p = 0; p < N_PHASES; p++) begin
      case (p / 2)
        0: begin
          tx_idle_pct = 9;
          rx_idle_pct = 66;
        end
        1: begin
          tx_idle_pct = 66;
          rx_idle_pct = 9;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      settle = (p == 4) ? 10'($urandom) : PHASE_SETTLE[p];
      configure(PHASE_ROWS[p], PHASE_BL[p], settle);
      counted = 0;
      while (counted < PHASE_WORDS) begin
        w = random_word();
        if ($urandom_range(99) < 2) drain(0);
        send_word(w);
        if (w.req.op <= OP_GLYPH) counted++;
      end
    end

    drain(DRAIN_CYCLES);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #6_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/clcd_pkg.sv
sv/clcd_front.sv
sv/clcd_queue.sv
sv/clcd_back.sv
sv/char_lcd_4bit_command_encoder.sv
test/char_lcd_4bit_command_encoder_tb.sv
